// ===== rtl/bilinear_upscale_by_three_defines.svh =====
// Assertion macros shared by the upscaler RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef BILINEAR_UPSCALE_BY_THREE_DEFINES_SVH
`define BILINEAR_UPSCALE_BY_THREE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BU3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bu3 assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BU3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bu3 assertion failed");
`else
`define BU3_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BU3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bu3_pkg.sv =====
// Shared constants and types for the 3x bilinear upscaler.
// No dependencies; used by the interfaces and the top-level module.
`timescale 1ns / 1ps

package bu3_pkg;

    // Frame geometry limits and derived counter widths.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths.
    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int OUT_ROW_W    = 14;
    localparam int OUT_COL_W    = 12;

    // Register reset values.
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Weighted sum is at most 9 * 255; divide by 9 via reciprocal multiply.
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam int RECIP9      = 7282;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Cells a source pixel completes, emitted inner, last column, last row.
    typedef struct packed {
        logic last_row;
        logic last_col;
        logic inner;
    } t_cells;

endpackage

// ===== rtl/bu3_if.sv =====
// Valid/ready stream interfaces for source pixels and output pixels.
// Depends on bu3_pkg for field widths.
`timescale 1ns / 1ps

interface bu3_pix_if;
    import bu3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bu3_res_if;
    import bu3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     value;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 last_of_run;

    modport source (output valid, output value, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

// ===== rtl/bu3_ram.sv =====
// Generic single-clock RAM, one write and one registered read port.
// Read returns the old contents when both ports hit one address.
`timescale 1ns / 1ps

module bu3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bilinear_upscale_by_three.sv =====
// Bilinear 3x upscaler top level: line store, cell sequencer, output pipe.
// Depends on bu3_pkg, bu3_if, bu3_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "bilinear_upscale_by_three_defines.svh"

// Usage:
// Source pixels of a frame arrive in raster order on i_pix (valid/ready).
// Each request may complete up to three 3x3 output cells: the inner cell up
// and left of it, the last-column cell at the end of a row, and its own
// cell in the last source row. Output pixels leave on o_res, cell by cell,
// row-major inside a cell, with last_of_run on the final one of a request.
// A taken request passes through the fetch, job and sum stages to the
// output register. Throughput: one output pixel per cycle while o_res.ready
// is high: an inner pixel yields 9 outputs, an edge pixel up to 27 and a
// source row 0 pixel completing no cell, none. The rate is set by the
// output port and single cell sequencer; one line store read per request.
// i_cfg_we writes frame_width (index 0) or frame_height (index 1) and
// restarts the frame; write only while the block is idle.
// Reset (synchronous, active low) restores 640 x 480, clears positions and
// pipeline valids. The 1024-entry line store is not cleared.
// When o_res.ready is low the output register holds and the pipe stalls;
// one request can still be taken into the fetch stage.
module bilinear_upscale_by_three (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  bu3_pkg::t_cfg_reg              i_cfg_idx,
    input  logic [bu3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bu3_pix_if.sink                        i_pix,
    bu3_res_if.source                      o_res
);
    import bu3_pkg::*;

    // Configuration and frame position.
    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    at_last_col;
    logic                    at_last_row;
    logic                    pix_acc;

    // Fetch stage: request waiting for its line store word.
    logic                    r_f_valid;
    logic [PIX_W-1:0]        r_f_px;
    logic [COL_W-1:0]        r_f_col;
    logic [ROW_W-1:0]        r_f_row;
    t_cells                  r_f_cells;
    logic [PIX_W-1:0]        up_px;

    // Job stage: corners and remaining cells of the request being emitted.
    logic                    r_j_valid;
    t_cells                  r_j_cells, n_j_cells;
    logic [COL_W-1:0]        r_j_col;
    logic [ROW_W-1:0]        r_j_row;
    logic [PIX_W-1:0]        r_j_ul, r_j_up, r_j_left, r_j_px;
    logic [1:0]              r_dy, r_dx;
    logic [PIX_W-1:0]        r_ul, r_left;
    t_cells                  cur;
    logic                    cell_done;
    logic                    job_done;
    logic                    take;
    logic                    adv;

    // Emitter datapath.
    logic [PIX_W-1:0]        p00, p01, p10, p11;
    logic [1:0]              wy0, wx0;
    logic [3:0]              w00, w01, w10, w11;
    logic [SUM_W-1:0]        em_sum;
    logic [ROW_W-1:0]        cell_row;
    logic [COL_W-1:0]        cell_col;
    logic [OUT_ROW_W-1:0]    em_row;
    logic [OUT_COL_W-1:0]    em_col;

    // Sum stage and output register.
    logic                    r_s_valid;
    logic [SUM_W-1:0]        r_s_sum;
    logic [OUT_ROW_W-1:0]    r_s_row;
    logic [OUT_COL_W-1:0]    r_s_col;
    logic                    r_s_last;
    logic [SUM_W+RECIP_W-1:0] div_prod;
    logic                    r_o_valid;
    logic [PIX_W-1:0]        r_o_value;
    logic [OUT_ROW_W-1:0]    r_o_row;
    logic [OUT_COL_W-1:0]    r_o_col;
    logic                    r_o_last;

    // Clamp geometry to the supported range.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WIDTH_REG_W'(1);
        end else if (r_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = HEIGHT_REG_W'(1);
        end else if (r_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign at_last_col = (WIDTH_REG_W'(r_col) == w_eff - 1'b1);
    assign at_last_row = (HEIGHT_REG_W'(r_row) == h_eff - 1'b1);

    // Raster position advance.
    always_comb begin
        n_col = r_col + 1'b1;
        n_row = r_row;
        if (at_last_col) begin
            n_col = '0;
            n_row = at_last_row ? '0 : r_row + 1'b1;
        end
    end

    // Handshake: the fetch slot frees when its request moves to the job stage.
    assign adv       = !r_o_valid || o_res.ready;
    assign cur.inner    = r_j_cells.inner;
    assign cur.last_col = !r_j_cells.inner && r_j_cells.last_col;
    assign cur.last_row = !r_j_cells.inner && !r_j_cells.last_col;
    assign n_j_cells = r_j_cells & ~cur;
    assign cell_done = (r_dy == 2'd2) && (r_dx == 2'd2);
    assign job_done  = cell_done && (n_j_cells == '0);
    assign take      = r_f_valid && (!r_j_valid || (adv && job_done));
    assign i_pix.ready = !r_f_valid || take;
    assign pix_acc   = i_pix.valid && i_pix.ready;

    // Line store: read the row above and write this pixel at one address.
    bu3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_col),
        .i_wdata (i_pix.pixel),
        .i_re    (pix_acc),
        .i_raddr (r_col),
        .o_rdata (up_px)
    );

    // Configuration registers and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_W'(WIDTH_RESET);
            r_height <= HEIGHT_REG_W'(HEIGHT_RESET);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default:          r_width  <= r_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Fetch stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (pix_acc) begin
            r_f_valid <= 1'b1;
        end else if (take) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_f_px             <= i_pix.pixel;
            r_f_col            <= r_col;
            r_f_row            <= r_row;
            r_f_cells.inner    <= (r_row != '0) && (r_col != '0);
            r_f_cells.last_col <= (r_row != '0) && at_last_col;
            r_f_cells.last_row <= at_last_row;
        end
    end

    // Job stage control: load from fetch, step through dy/dx and cells.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
            r_ul      <= '0;
            r_left    <= '0;
            r_dy      <= '0;
            r_dx      <= '0;
            r_j_cells <= '0;
        end else if (take) begin
            r_j_valid <= (r_f_cells != '0);
            r_j_cells <= r_f_cells;
            r_dy      <= '0;
            r_dx      <= '0;
            r_ul      <= up_px;
            r_left    <= r_f_px;
        end else if (r_j_valid && adv) begin
            if (r_dx != 2'd2) begin
                r_dx <= r_dx + 1'b1;
            end else begin
                r_dx <= '0;
                if (r_dy != 2'd2) begin
                    r_dy <= r_dy + 1'b1;
                end else begin
                    r_dy      <= '0;
                    r_j_cells <= n_j_cells;
                    r_j_valid <= (n_j_cells != '0);
                end
            end
        end
    end

    // Job stage corners.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_j_ul   <= r_ul;
            r_j_up   <= up_px;
            r_j_left <= r_left;
            r_j_px   <= r_f_px;
            r_j_col  <= r_f_col;
            r_j_row  <= r_f_row;
        end
    end

    // Corner selection: edge cells replicate one pixel.
    always_comb begin
        priority if (cur.inner) begin
            p00 = r_j_ul;
            p01 = r_j_up;
            p10 = r_j_left;
            p11 = r_j_px;
        end else if (cur.last_col) begin
            p00 = r_j_up;
            p01 = r_j_up;
            p10 = r_j_up;
            p11 = r_j_up;
        end else begin
            p00 = r_j_px;
            p01 = r_j_px;
            p10 = r_j_px;
            p11 = r_j_px;
        end
    end

    // Bilinear weights (3-d, d) and the weighted sum.
    assign wy0 = 2'd3 - r_dy;
    assign wx0 = 2'd3 - r_dx;
    assign w00 = 4'(wy0) * 4'(wx0);
    assign w01 = 4'(wy0) * 4'(r_dx);
    assign w10 = 4'(r_dy) * 4'(wx0);
    assign w11 = 4'(r_dy) * 4'(r_dx);
    assign em_sum = SUM_W'(w00) * SUM_W'(p00) + SUM_W'(w01) * SUM_W'(p01)
                  + SUM_W'(w10) * SUM_W'(p10) + SUM_W'(w11) * SUM_W'(p11);

    // Output coordinates: inner cell sits one row up and one column left.
    assign cell_row = cur.last_row ? r_j_row : r_j_row - 1'b1;
    assign cell_col = cur.inner ? r_j_col - 1'b1 : r_j_col;
    assign em_row = OUT_ROW_W'({cell_row, 1'b0}) + OUT_ROW_W'(cell_row)
                  + OUT_ROW_W'(r_dy);
    assign em_col = OUT_COL_W'({cell_col, 1'b0}) + OUT_COL_W'(cell_col)
                  + OUT_COL_W'(r_dx);

    // Divide by nine via reciprocal multiply (exact for sums up to 9*255).
    assign div_prod = SUM_W'(r_s_sum) * RECIP_W'(RECIP9);

    // Sum stage and output register valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_s_valid <= r_j_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s_sum   <= em_sum;
            r_s_row   <= em_row;
            r_s_col   <= em_col;
            r_s_last  <= job_done;
            r_o_value <= div_prod[RECIP_SHIFT +: PIX_W];
            r_o_row   <= r_s_row;
            r_o_col   <= r_s_col;
            r_o_last  <= r_s_last;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.value       = r_o_value;
    assign o_res.out_row     = r_o_row;
    assign o_res.out_col     = r_o_col;
    assign o_res.last_of_run = r_o_last;

    // A live job always has a cell left to emit.
    `BU3_ASSERT_IMP(a_job_has_cell, i_clk, i_rst_n, r_j_valid, r_j_cells != 3'b000)
    // A taken request lands in the fetch stage.
    `BU3_ASSERT_NEXT(a_fetch_loaded, i_clk, i_rst_n, pix_acc, r_f_valid)
    // Sub-pixel counters stay within the 3x3 cell.
    `BU3_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, r_j_valid, (r_dy != 2'd3) && (r_dx != 2'd3))
    // Output columns stay inside the enlarged maximum-width frame.
    `BU3_ASSERT_IMP(a_col_range, i_clk, i_rst_n, r_o_valid,
        r_o_col < OUT_COL_W'(3 * MAX_WIDTH))

endmodule
